>>> src/tknh_pkg.sv
// Shared types and constants for the top-k nearest max-heap block.
// Used by the engine and the top level; depends on nothing.
package tknh_pkg;

    localparam int MAX_KEEP = 64;
    localparam int ADDR_W   = $clog2(MAX_KEEP);
    localparam int FILL_W   = $clog2(MAX_KEEP + 1);
    localparam int KEEP_W   = 7;
    localparam int DIST_W   = 32;
    localparam int ID_W     = 32;
    localparam int ENTRY_W  = DIST_W + ID_W;

    localparam logic [ID_W-1:0]   ID_NONE   = '1;
    localparam logic [DIST_W-1:0] DIST_HIGH = '1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_BOUND  = 2'd1,
        CMD_READ   = 2'd2
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_UP_PUT,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [DIST_W-1:0]      distance;
        logic signed [ID_W-1:0] ident;
    } entry_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [DIST_W-1:0]      distance;
        logic signed [ID_W-1:0] ident;
        logic [5:0]             read_index;
    } cmd_t;

    typedef struct packed {
        logic                   accepted;
        logic [DIST_W-1:0]      bound;
        logic [6:0]             fill;
        logic [DIST_W-1:0]      entry_distance;
        logic signed [ID_W-1:0] entry_ident;
        logic                   entry_valid;
    } res_t;

endpackage

>>> src/tknh_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module tknh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/tknh_engine.sv
// Heap engine: command sequencer, sift up and sift down over the entry RAM, result register.
// Depends on tknh_pkg and tknh_ram.
module tknh_engine
    import tknh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [FILL_W-1:0] keep_k,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output res_t              result
);

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    entry_t item_reg, item_next;
    entry_t left_reg, left_next;
    logic has_right_reg, has_right_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [DIST_W-1:0] root_reg, root_next;
    logic acc_reg, acc_next;
    res_t res_reg, res_next;
    logic done_reg, done_next;

    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t wr_data;
    logic rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    entry_t rd_entry;

    entry_t in_entry;
    logic ins_fits, ins_beats, rd_ok;
    logic [ADDR_W-1:0] new_parent, parent_idx, grand_idx, pick_idx;
    logic [ADDR_W+1:0] lc_idx, rc_idx, fill_ext;
    logic dn_leaf, dn_has_right, pick_right, dn_move, up_move;
    entry_t pick_entry;
    logic finish;
    logic [DIST_W-1:0] e_dist;
    logic [ID_W-1:0] e_id;
    logic e_valid;

    tknh_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_KEEP)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);
    assign in_entry = '{distance: cmd.distance, ident: cmd.ident};

    assign ins_fits   = fill_reg < keep_k;
    assign ins_beats  = cmd.distance < root_reg;
    assign rd_ok      = FILL_W'(cmd.read_index) < fill_reg;
    assign new_parent = ADDR_W'((fill_reg - FILL_W'(1)) >> 1);
    assign parent_idx = ADDR_W'((pos_reg - ADDR_W'(1)) >> 1);
    assign grand_idx  = ADDR_W'((parent_idx - ADDR_W'(1)) >> 1);
    assign up_move    = rd_entry.distance < item_reg.distance;

    assign lc_idx       = {1'b0, pos_reg, 1'b1};
    assign rc_idx       = lc_idx + (ADDR_W+2)'(1);
    assign fill_ext     = (ADDR_W+2)'(fill_reg);
    assign dn_leaf      = lc_idx >= fill_ext;
    assign dn_has_right = rc_idx < fill_ext;
    assign pick_right   = has_right_reg && (left_reg.distance < rd_entry.distance);
    assign pick_entry   = pick_right ? rd_entry : left_reg;
    assign pick_idx     = pick_right ? rc_idx[ADDR_W-1:0] : lc_idx[ADDR_W-1:0];
    assign dn_move      = item_reg.distance < pick_entry.distance;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (ins_fits)
                            begin
                                state_next = (fill_reg == '0) ? ST_IDLE : ST_UP_CMP;
                            end
                            else if (ins_beats)
                            begin
                                state_next = ST_DN_LEFT;
                            end
                        end
                        CMD_READ:
                        begin
                            state_next = rd_ok ? ST_READ : ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UP_CMP:
            begin
                if (up_move)
                begin
                    state_next = (parent_idx == '0) ? ST_UP_PUT : ST_UP_CMP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UP_PUT:   state_next = ST_IDLE;
            ST_DN_LEFT:  state_next = dn_leaf ? ST_IDLE : ST_DN_RIGHT;
            ST_DN_RIGHT: state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = dn_move ? ST_DN_LEFT : ST_IDLE;
            ST_READ:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        item_next      = item_reg;
        left_next      = left_reg;
        has_right_next = has_right_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = item_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        finish         = 1'b0;
        e_dist         = '0;
        e_id           = ID_NONE;
        e_valid        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    acc_next = 1'b0;
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            item_next = in_entry;
                            if (ins_fits)
                            begin
                                acc_next  = 1'b1;
                                pos_next  = fill_reg[ADDR_W-1:0];
                                fill_next = fill_reg + FILL_W'(1);
                                if (fill_reg == '0)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = '0;
                                    wr_data = in_entry;
                                    finish  = 1'b1;
                                end
                                else
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = new_parent;
                                end
                            end
                            else if (ins_beats)
                            begin
                                acc_next = 1'b1;
                                pos_next = '0;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        CMD_BOUND:
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = '0;
                            wr_data   = '{distance: cmd.distance, ident: ID_NONE};
                            fill_next = FILL_W'(1);
                            finish    = 1'b1;
                        end
                        CMD_READ:
                        begin
                            if (rd_ok)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = cmd.read_index;
                            end
                            else
                            begin
                                finish = 1'b1;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (up_move)
                begin
                    wr_data  = rd_entry;
                    pos_next = parent_idx;
                    if (parent_idx != '0)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = grand_idx;
                    end
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            ST_UP_PUT:
            begin
                wr_en  = 1'b1;
                finish = 1'b1;
            end
            ST_DN_LEFT:
            begin
                if (dn_leaf)
                begin
                    wr_en  = 1'b1;
                    finish = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = lc_idx[ADDR_W-1:0];
                end
            end
            ST_DN_RIGHT:
            begin
                left_next      = rd_entry;
                has_right_next = dn_has_right;
                if (dn_has_right)
                begin
                    rd_en   = 1'b1;
                    rd_addr = rc_idx[ADDR_W-1:0];
                end
            end
            ST_DN_CMP:
            begin
                wr_en = 1'b1;
                if (dn_move)
                begin
                    wr_data  = pick_entry;
                    pos_next = pick_idx;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            ST_READ:
            begin
                e_dist  = rd_entry.distance;
                e_id    = rd_entry.ident;
                e_valid = 1'b1;
                finish  = 1'b1;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase

        root_next = root_reg;
        if (wr_en && (wr_addr == '0))
        begin
            root_next = wr_data.distance;
        end

        done_next = finish;
        res_next  = res_reg;
        if (finish)
        begin
            res_next.accepted       = acc_next;
            res_next.bound          = root_next;
            res_next.fill           = 7'(fill_next);
            res_next.entry_distance = e_dist;
            res_next.entry_ident    = e_id;
            res_next.entry_valid    = e_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            root_reg  <= DIST_HIGH;
            acc_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            root_reg  <= root_next;
            acc_reg   <= acc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        item_reg      <= item_next;
        left_reg      <= left_next;
        has_right_reg <= has_right_next;
        res_reg       <= res_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> src/topk_nearest_max_heap_top.sv
// Top level of the top-k nearest max-heap: keep-count register and heap engine.
// Depends on tknh_pkg and tknh_engine.
//
// Channel   Signals                        Transaction when
// command   start, busy, cmd               start high and busy low at a rising edge
// result    done, result                   done high (one cycle, cannot be stalled)
// config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high at a rising edge
//
// The result appears in the cycle after the last engine cycle of a command.
// Insert below k reads the parent and climbs a level per compare; insert into an
// empty heap writes the root at once. Replacement at the root reads the left child,
// then the right child, then compares, per level, in an order set by the single read
// port of the entry RAM. Read of a held entry waits on the RAM read; others end at once.
// Reset empties the heap and sets the bound to all ones; no clearing pass is needed.
module topk_nearest_max_heap_top
    import tknh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output res_t              result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEEP_W-1:0] cfg_data
);

    logic [KEEP_W-1:0] keep_count_reg, keep_count_next;
    logic [FILL_W-1:0] keep_k;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        keep_count_next = keep_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            keep_count_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_W'(1);
        end
        else
        begin
            keep_count_reg <= keep_count_next;
        end
    end

    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            keep_k = FILL_W'(1);
        end
        else if (32'(keep_count_reg) > 32'(MAX_KEEP))
        begin
            keep_k = FILL_W'(MAX_KEEP);
        end
        else
        begin
            keep_k = FILL_W'(keep_count_reg);
        end
    end

    tknh_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .keep_k(keep_k),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .result(result)
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for topk_nearest_max_heap_top: a directed table, then random phases.
// Each result is checked against a fixed expected value or a heap predictor kept in this file.
// Depends on tknh_pkg and topk_nearest_max_heap_top.
module tb_top;
    import tknh_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASE_COUNT = 9;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [KEEP_W-1:0] keep;
        cmd_t              item;
        res_t              want;
    } step_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cmd_t              cmd;
    logic              done;
    res_t              result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [KEEP_W-1:0] cfg_data;

    logic [DIST_W-1:0] heap_dist [MAX_KEEP];
    logic [ID_W-1:0]   heap_ident [MAX_KEEP];
    int unsigned       heap_fill;
    logic [KEEP_W-1:0] keep_reg;

    res_t      pending_results [$];
    step_row_t script [$];
    int        errors = 0;
    int        cycles = 0;
    bit        steady = 1'b0;

    topk_nearest_max_heap_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned keep_limit();
        int unsigned k;
        k = 32'(keep_reg);
        if (k < 1) k = 1;
        if (k > MAX_KEEP) k = MAX_KEEP;
        return k;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [DIST_W-1:0] d;
        logic [ID_W-1:0]   i;
        d = heap_dist[a];
        heap_dist[a] = heap_dist[b];
        heap_dist[b] = d;
        i = heap_ident[a];
        heap_ident[a] = heap_ident[b];
        heap_ident[b] = i;
    endfunction

    function automatic res_t next_heap_result(cmd_t c);
        res_t        r;
        int unsigned pos;
        int unsigned up;
        int unsigned lc;
        int unsigned pick;
        bit          moving;
        r = '0;
        r.entry_ident = ID_NONE;
        case (c.command)
            CMD_INSERT:
            begin
                if (heap_fill < keep_limit())
                begin
                    pos = heap_fill;
                    heap_dist[pos] = c.distance;
                    heap_ident[pos] = c.ident;
                    moving = 1'b1;
                    while (moving && pos != 0)
                    begin
                        up = (pos - 1) >> 1;
                        if (heap_dist[up] < heap_dist[pos])
                        begin
                            swap_slots(up, pos);
                            pos = up;
                        end
                        else
                            moving = 1'b0;
                    end
                    heap_fill++;
                    r.accepted = 1'b1;
                end
                else if (c.distance < heap_dist[0])
                begin
                    heap_dist[0] = c.distance;
                    heap_ident[0] = c.ident;
                    pos = 0;
                    moving = 1'b1;
                    while (moving)
                    begin
                        lc = 2 * pos + 1;
                        if (lc >= heap_fill)
                            moving = 1'b0;
                        else
                        begin
                            pick = lc;
                            if (lc + 1 < heap_fill && heap_dist[lc] < heap_dist[lc + 1])
                                pick = lc + 1;
                            if (heap_dist[pos] < heap_dist[pick])
                            begin
                                swap_slots(pos, pick);
                                pos = pick;
                            end
                            else
                                moving = 1'b0;
                        end
                    end
                    r.accepted = 1'b1;
                end
            end
            CMD_BOUND:
            begin
                heap_dist[0] = c.distance;
                heap_ident[0] = ID_NONE;
                heap_fill = 1;
            end
            CMD_READ:
            begin
                if (c.read_index < heap_fill)
                begin
                    r.entry_distance = heap_dist[c.read_index];
                    r.entry_ident = heap_ident[c.read_index];
                    r.entry_valid = 1'b1;
                end
            end
            default: ;
        endcase
        r.bound = heap_dist[0];
        r.fill = 7'(heap_fill);
        return r;
    endfunction

    function automatic res_t known(logic acc, logic [DIST_W-1:0] bnd, logic [6:0] fl,
                                   logic [DIST_W-1:0] ed, logic [ID_W-1:0] eid, logic ev);
        res_t r;
        r.accepted = acc;
        r.bound = bnd;
        r.fill = fl;
        r.entry_distance = ed;
        r.entry_ident = eid;
        r.entry_valid = ev;
        return r;
    endfunction

    function automatic step_row_t item_row(row_kind_t kind, logic [1:0] op,
                                           logic [DIST_W-1:0] d, logic [ID_W-1:0] id,
                                           logic [5:0] ix, res_t want);
        step_row_t r;
        r.kind = kind;
        r.keep = '0;
        r.item.command = op;
        r.item.distance = d;
        r.item.ident = id;
        r.item.read_index = ix;
        r.want = want;
        return r;
    endfunction

    function automatic step_row_t cfg_row(logic [KEEP_W-1:0] v);
        step_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.keep = v;
        return r;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned n;
        n = 0;
        if (!steady)
            while ($urandom_range(0, 99) < 15) n++;
        return n;
    endfunction

    function automatic cmd_t random_item();
        cmd_t        c;
        int unsigned sel;
        bit          full;
        full = heap_fill >= keep_limit();
        sel = $urandom_range(0, 99);
        c.distance = $urandom;
        c.ident = ($urandom_range(0, 9) == 0) ? ID_NONE : {1'b0, 31'($urandom)};
        c.read_index = 6'($urandom_range(0, 63));
        if (sel < (full ? 62 : 75))
        begin
            c.command = CMD_INSERT;
            sel = $urandom_range(0, 99);
            if (sel < 25)
                c.distance = $urandom_range(0, 15);
            else if (sel < 35)
                c.distance = heap_dist[0];
            else if (sel < 70 && heap_dist[0] != 0)
                c.distance = $urandom_range(0, heap_dist[0] - 1);
        end
        else if (sel < (full ? 87 : 95))
        begin
            c.command = CMD_READ;
            if (heap_fill != 0 && $urandom_range(0, 4) != 0)
                c.read_index = 6'($urandom_range(0, heap_fill - 1));
        end
        else if (full && sel < 94)
            c.command = CMD_BOUND;
        else
            c.command = CMD_NONE;
        return c;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 100)
            $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // A command transaction: start is held high until an edge with busy low.
    task automatic issue(cmd_t c, res_t want, bit typed);
        res_t        predicted;
        int unsigned gap;
        gap = idle_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = next_heap_result(c);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_keep(logic [KEEP_W-1:0] v);
        int unsigned gap;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        gap = idle_gap();
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        keep_reg = v;
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("result with none expected, bound", 64'(result.bound), '0);
            else
            begin
                want = pending_results.pop_front();
                if (result.accepted !== want.accepted)
                    flag_mismatch("accepted", 64'(result.accepted), 64'(want.accepted));
                if (result.bound !== want.bound)
                    flag_mismatch("bound", 64'(result.bound), 64'(want.bound));
                if (result.fill !== want.fill)
                    flag_mismatch("fill", 64'(result.fill), 64'(want.fill));
                if (result.entry_distance !== want.entry_distance)
                    flag_mismatch("entry_distance", 64'(result.entry_distance),
                                  64'(want.entry_distance));
                if (result.entry_ident !== want.entry_ident)
                    flag_mismatch("entry_ident", 64'(result.entry_ident),
                                  64'(want.entry_ident));
                if (result.entry_valid !== want.entry_valid)
                    flag_mismatch("entry_valid", 64'(result.entry_valid),
                                  64'(want.entry_valid));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        step_row_t         r;
        logic [KEEP_W-1:0] k;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            heap_dist[i] = '0;
            heap_ident[i] = '0;
        end
        heap_dist[0] = DIST_HIGH;
        heap_fill = 0;
        keep_reg = 7'd1;

        // After reset the heap is empty and the bound is all ones.
        script.push_back(item_row(ROW_KNOWN, CMD_READ, 32'd0, 32'd0, 6'd0,
                                  known(1'b0, DIST_HIGH, 7'd0, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_INSERT, DIST_HIGH, 32'd1, 6'd0,
                                  known(1'b1, DIST_HIGH, 7'd1, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_INSERT, DIST_HIGH, 32'd2, 6'd63,
                                  known(1'b0, DIST_HIGH, 7'd1, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_INSERT, 32'd0, 32'h7FFF_FFFF, 6'd0,
                                  known(1'b1, 32'd0, 7'd1, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_READ, DIST_HIGH, ID_NONE, 6'd0,
                                  known(1'b0, 32'd0, 7'd1, 32'd0, 32'h7FFF_FFFF, 1'b1)));
        script.push_back(item_row(ROW_KNOWN, CMD_READ, 32'd0, 32'd0, 6'd63,
                                  known(1'b0, 32'd0, 7'd1, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_NONE, DIST_HIGH, 32'd0, 6'd63,
                                  known(1'b0, 32'd0, 7'd1, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_BOUND, 32'h8000_0000, 32'h1234, 6'd0,
                                  known(1'b0, 32'h8000_0000, 7'd1, 32'd0, ID_NONE, 1'b0)));
        script.push_back(item_row(ROW_KNOWN, CMD_READ, 32'd0, 32'd0, 6'd0,
                                  known(1'b0, 32'h8000_0000, 7'd1, 32'h8000_0000,
                                        ID_NONE, 1'b1)));
        script.push_back(cfg_row(7'd127));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd9, 32'd11, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd9, 32'd12, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd3, 32'd13, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd9, 32'd14, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'hFFFF_FFFE, 32'd15, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd9, ID_NONE, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_READ, 32'd0, 32'd0, 6'd1, '0));
        script.push_back(item_row(ROW_ITEM, CMD_READ, 32'd0, 32'd0, 6'd5, '0));
        // Lowering k below the fill level keeps every entry and makes the heap full.
        script.push_back(cfg_row(7'd2));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd4, 32'd19, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd9, 32'd20, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_READ, 32'd0, 32'd0, 6'd2, '0));
        script.push_back(item_row(ROW_ITEM, CMD_READ, 32'd0, 32'd0, 6'd6, '0));
        script.push_back(cfg_row(7'd0));
        script.push_back(item_row(ROW_ITEM, CMD_INSERT, 32'd1, ID_NONE, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_READ, 32'd0, 32'd0, 6'd0, '0));
        script.push_back(item_row(ROW_ITEM, CMD_READ, 32'd0, 32'd0, 6'd6, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            r = script[i];
            if (r.kind == ROW_CFG)
                write_keep(r.keep);
            else
                issue(r.item, r.want, r.kind == ROW_KNOWN);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: k = 7'd64;
                1: k = 7'd3;
                2: k = 7'd127;
                3: k = 7'd0;
                4: k = 7'd40;
                5: k = 7'd1;
                6: k = 7'($urandom_range(1, 64));
                7: k = 7'd64;
                default: k = 7'($urandom_range(0, 127));
            endcase
            steady = (phase == 2 || phase == 7);
            write_keep(k);
            repeat (PHASE_ITEMS) issue(random_item(), '0, 1'b0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
src/tknh_pkg.sv
src/tknh_ram.sv
src/tknh_engine.sv
src/topk_nearest_max_heap_top.sv
tb/sv/tb_top.sv
